// ===== rtl/itc_pkg.sv =====
// Package for the integer-to-text formatter: state codes, operation codes,
// the narrowed-argument struct, character codes and small helper functions.
// No dependencies.
package itc_pkg;

  // Argument and digit geometry
  localparam int VAL_W       = 64;
  localparam int DIG_W       = 4;
  localparam int NUM_DIG     = 22;
  localparam int ND_W        = 5;
  localparam int MAX_RESULTS = 34;
  localparam int OUT_W       = 6;
  localparam int CONV_CYC    = 64;
  localparam int CONV_W      = 6;
  localparam int PRE_LEN     = 5;
  localparam int PRE_W       = 3;

  // Operation codes
  localparam logic [3:0] OP_DI    = 4'd0;
  localparam logic [3:0] OP_U     = 4'd1;
  localparam logic [3:0] OP_O     = 4'd2;
  localparam logic [3:0] OP_XL    = 4'd3;
  localparam logic [3:0] OP_XU    = 4'd4;
  localparam logic [3:0] OP_C     = 4'd5;
  localparam logic [3:0] OP_SL    = 4'd6;
  localparam logic [3:0] OP_SU    = 4'd7;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SETUP = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // Argument after narrowing and sign handling
  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
    logic             nz;
    logic [7:0]       low_byte;
  } narrow_t;

  // Byte size implied by a length modifier, zero where none is implied
  function automatic logic [3:0] mod_size(input logic [3:0] lm);
    logic [3:0] s;
    unique case (lm)
      4'd1, 4'd11:                            s = 4'd1;
      4'd2, 4'd12:                            s = 4'd2;
      4'd9:                                   s = 4'd4;
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10: s = 4'd8;
      default:                                s = 4'd0;
    endcase
    return s;
  endfunction

  // Digit value to its character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = 8'h37 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/itc_narrow.sv =====
// Argument narrowing: clamps the byte size, applies the length modifier,
// sign-extends for signed d/i and forms the magnitude. Uses itc_pkg.
module itc_narrow (
  input  logic [3:0]           op,
  input  logic [63:0]          value,
  input  logic                 is_signed,
  input  logic [3:0]           size_bytes,
  input  logic [3:0]           length_mod,
  output itc_pkg::narrow_t     res
);
  import itc_pkg::*;

  logic [3:0]       sz;
  logic [3:0]       ms;
  logic             sb;
  logic             ext;
  logic             sgn;
  logic [VAL_W-1:0] nv;

  // Effective byte size
  always_comb begin
    ms = mod_size(length_mod);
    sz = (size_bytes > 4'd8) ? 4'd8 : size_bytes;
    if (ms != 4'd0 && sz > ms) begin
      sz = ms;
    end
  end

  // Top bit of the narrowed argument
  always_comb begin
    case (sz)
      4'd1:    sb = value[7];
      4'd2:    sb = value[15];
      4'd3:    sb = value[23];
      4'd4:    sb = value[31];
      4'd5:    sb = value[39];
      4'd6:    sb = value[47];
      4'd7:    sb = value[55];
      default: sb = 1'b0;
    endcase
  end

  assign sgn = (op == OP_DI) && is_signed;
  assign ext = sgn && sb;

  // Keep low bytes, fill the rest with sign or zero
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < sz) begin
        nv[8*b +: 8] = value[8*b +: 8];
      end else begin
        nv[8*b +: 8] = ext ? 8'hff : 8'h00;
      end
    end
  end

  assign res.neg      = sgn && nv[VAL_W-1];
  assign res.mag      = res.neg ? (VAL_W'(0) - nv) : nv;
  assign res.nz       = (nv != '0);
  assign res.low_byte = nv[7:0];

endmodule

// ===== rtl/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter: item capture, digit
// conversion by shift-and-add-3, leading-zero scan and character emitter.
// Depends on itc_pkg and itc_narrow.
//
// Usage: raise start with the conversion fields while busy is low; the item
// is taken at that edge and busy rises on the next cycle. Characters come out
// one per cycle on out_char, each marked by a one-cycle strobe, with last on
// the final one and status high only for an unsupported conversion (a single
// NUL character). The receiver cannot stall the block.
// Per item: decimal d/i/u pass through the shift-and-add-3 converter, one
// argument bit a cycle; every integer op then scans off leading zero digits
// one per cycle (up to 21), passes through the setup state and emits one
// character a cycle (at most 34). Octal and hex skip the converter. %c, %s,
// %S and unsupported ops go from idle to setup and then emit their characters.
// busy falls in the cycle that shows the last character, so the next item may
// be taken then. Synchronous reset returns the block to idle with no strobe.
module integer_to_text_formatter #(
  parameter int MAX_PRECISION = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic [63:0] value,
  input  logic        is_signed,
  input  logic [3:0]  size_bytes,
  input  logic [3:0]  length_mod,
  input  logic        plus_sign,
  input  logic        space_sign,
  input  logic        alt_form,
  input  logic        group_sep,
  input  logic        has_precision,
  input  logic [5:0]  precision,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        status
);
  import itc_pkg::*;

  localparam int CNT_W = $clog2(MAX_PRECISION + 2 * NUM_DIG + 8);

  state_t                          state;
  narrow_t                         nres;
  logic [NUM_DIG-1:0][DIG_W-1:0]   dig;
  logic [NUM_DIG-1:0][DIG_W-1:0]   dig_load;
  logic [NUM_DIG-1:0][DIG_W-1:0]   dig_adj;
  logic [NUM_DIG*3-1:0]            oct_src;
  logic [NUM_DIG*DIG_W-1:0]        hex_src;
  logic [VAL_W-1:0]                mag;
  logic [CONV_W-1:0]               ccnt;
  logic [ND_W-1:0]                 nd;
  logic [ND_W-1:0]                 ndm1;
  logic [ND_W-1:0]                 q3;
  logic [1:0]                      r3;
  logic [ND_W-1:0]                 rem;
  logic [1:0]                      mod3;
  logic                            comma_pend;
  logic [PRE_LEN-1:0][7:0]         pre;
  logic [PRE_LEN-1:0][7:0]         pre_load;
  logic [PRE_W-1:0]                npre;
  logic [PRE_W-1:0]                npre_load;
  logic [CNT_W-1:0]                nzero;
  logic [OUT_W-1:0]                out_left;
  logic                            is_int;
  logic                            grouped;
  logic                            upper;
  logic                            oct_hash;
  logic                            has_prec;
  logic [5:0]                      prec;
  logic                            nz;
  logic                            unsup;

  logic [CNT_W-1:0]                len;
  logic [CNT_W-1:0]                psat;
  logic [CNT_W-1:0]                nzero_calc;
  logic [CNT_W-1:0]                total;
  logic [7:0]                      ch;

  itc_narrow u_narrow (
    .op         (op),
    .value      (value),
    .is_signed  (is_signed),
    .size_bytes (size_bytes),
    .length_mod (length_mod),
    .res        (nres)
  );

  assign busy = (state != ST_IDLE);

  // Prefix or text characters for a new item
  always_comb begin
    int idx;
    idx       = 0;
    pre_load  = '0;
    npre_load = '0;
    if (op > OP_SU) begin
      pre_load[0] = CH_NUL;
      npre_load   = PRE_W'(1);
    end else if (op == OP_C) begin
      pre_load[0] = nres.low_byte;
      npre_load   = PRE_W'(1);
    end else if (op == OP_SL || op == OP_SU) begin
      if (nres.nz) begin
        pre_load[0] = (op == OP_SU) ? "T" : "t";
        pre_load[1] = (op == OP_SU) ? "R" : "r";
        pre_load[2] = (op == OP_SU) ? "U" : "u";
        pre_load[3] = (op == OP_SU) ? "E" : "e";
        npre_load   = PRE_W'(4);
      end else begin
        pre_load[0] = (op == OP_SU) ? "F" : "f";
        pre_load[1] = (op == OP_SU) ? "A" : "a";
        pre_load[2] = (op == OP_SU) ? "L" : "l";
        pre_load[3] = (op == OP_SU) ? "S" : "s";
        pre_load[4] = (op == OP_SU) ? "E" : "e";
        npre_load   = PRE_W'(5);
      end
    end else begin
      // sign for signed d/i
      if (op == OP_DI && is_signed) begin
        if (nres.neg) begin
          pre_load[idx] = CH_MINUS;
          idx++;
        end else if (plus_sign) begin
          pre_load[idx] = CH_PLUS;
          idx++;
        end else if (space_sign) begin
          pre_load[idx] = CH_SPACE;
          idx++;
        end
      end
      // 0x prefix for nonzero hex under the alternate form
      if ((op == OP_XL || op == OP_XU) && alt_form && nres.nz) begin
        pre_load[idx]     = CH_ZERO;
        pre_load[idx + 1] = (op == OP_XU) ? CH_XU : CH_XL;
        idx += 2;
      end
      npre_load = PRE_W'(idx);
    end
  end

  // Direct digit split for octal and hex
  always_comb begin
    oct_src = {(NUM_DIG*3-VAL_W)'(0), nres.mag};
    hex_src = {(NUM_DIG*DIG_W-VAL_W)'(0), nres.mag};
    for (int i = 0; i < NUM_DIG; i++) begin
      if (op == OP_O) begin
        dig_load[i] = {1'b0, oct_src[3*i +: 3]};
      end else begin
        dig_load[i] = hex_src[DIG_W*i +: DIG_W];
      end
    end
  end

  // Add-3 correction ahead of each shift
  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      dig_adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
    end
  end

  // nd - 1 split by three: multiply by 11/32, exact for 0..31
  always_comb begin
    ndm1 = nd - ND_W'(1);
    q3   = ND_W'(({{ND_W{1'b0}}, ndm1} * (2*ND_W)'(11)) >> ND_W);
    r3   = 2'(ndm1 - ND_W'({q3, 1'b0} + {1'b0, q3}));
  end

  // Body length, zero padding and run length
  always_comb begin
    len = CNT_W'(nd);
    if (grouped) begin
      len = CNT_W'(nd) + CNT_W'(q3);
    end
    if (!is_int) begin
      len = '0;
    end
    psat = (CNT_W'(prec) > CNT_W'(MAX_PRECISION)) ? CNT_W'(MAX_PRECISION) : CNT_W'(prec);
    nzero_calc = '0;
    if (is_int && has_prec && len < psat) begin
      nzero_calc = psat - len;
    end
    if (is_int && oct_hash && nz && nzero_calc == '0) begin
      nzero_calc = CNT_W'(1);
    end
    total = CNT_W'(npre) + nzero_calc + len;
  end

  // Character chosen in the emit state
  always_comb begin
    if (npre != '0) begin
      ch = pre[0];
    end else if (nzero != '0) begin
      ch = CH_ZERO;
    end else if (comma_pend) begin
      ch = CH_COMMA;
    end else begin
      ch = digit_char(dig[NUM_DIG-1], upper);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            pre      <= pre_load;
            npre     <= npre_load;
            is_int   <= (op <= OP_XU);
            unsup    <= (op > OP_SU);
            grouped  <= group_sep && (op == OP_DI || op == OP_U);
            upper    <= (op == OP_XU);
            oct_hash <= (op == OP_O) && alt_form;
            has_prec <= has_precision;
            prec     <= precision;
            nz       <= nres.nz;
            mag      <= nres.mag;
            ccnt     <= '0;
            if (op == OP_DI || op == OP_U) begin
              dig   <= '0;
              nd    <= ND_W'(NUM_DIG);
              state <= ST_CONV;
            end else if (op <= OP_XU) begin
              dig   <= dig_load;
              nd    <= ND_W'(NUM_DIG);
              state <= ST_SCAN;
            end else begin
              nd    <= '0;
              state <= ST_SETUP;
            end
          end
        end
        ST_CONV: begin
          // one argument bit into the decimal digits per cycle
          dig  <= (NUM_DIG*DIG_W)'({dig_adj, mag[VAL_W-1]});
          mag  <= {mag[VAL_W-2:0], 1'b0};
          ccnt <= ccnt + CONV_W'(1);
          if (ccnt == CONV_W'(CONV_CYC - 1)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (nd > ND_W'(1) && dig[NUM_DIG-1] == '0) begin
            dig <= {dig[NUM_DIG-2:0], {DIG_W{1'b0}}};
            nd  <= nd - ND_W'(1);
          end else begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          nzero      <= nzero_calc;
          out_left   <= (total > CNT_W'(MAX_RESULTS)) ? OUT_W'(MAX_RESULTS) : OUT_W'(total);
          rem        <= nd;
          mod3       <= is_int ? r3 : 2'd0;
          comma_pend <= 1'b0;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe   <= 1'b1;
          out_char <= ch;
          last     <= (out_left == OUT_W'(1));
          status   <= unsup;
          out_left <= out_left - OUT_W'(1);
          if (out_left == OUT_W'(1)) begin
            state <= ST_IDLE;
          end
          if (npre != '0) begin
            pre  <= {8'h00, pre[PRE_LEN-1:1]};
            npre <= npre - PRE_W'(1);
          end else if (nzero != '0) begin
            nzero <= nzero - CNT_W'(1);
          end else if (comma_pend) begin
            comma_pend <= 1'b0;
          end else begin
            dig  <= {dig[NUM_DIG-2:0], {DIG_W{1'b0}}};
            rem  <= rem - ND_W'(1);
            mod3 <= (mod3 == 2'd0) ? 2'd2 : mod3 - 2'd1;
            if (grouped && rem > ND_W'(1) && mod3 == 2'd0) begin
              comma_pend <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for integer_to_text_formatter: directed and random
// conversion requests, expected character runs predicted in place.
// Depends on itc_pkg and the formatter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itc_pkg::*;

  localparam int PREC_CAP  = 32;
  localparam int RUN_CAP   = 34;
  localparam int WD_LIMIT  = 4000;

  typedef struct {
    logic [3:0]  op;
    logic [63:0] value;
    logic        is_signed;
    logic [3:0]  size_bytes;
    logic [3:0]  length_mod;
    logic        plus_sign, space_sign, alt_form, group_sep;
    logic        has_precision;
    logic [5:0]  precision;
  } request_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       status;
  } char_t;

  logic        clk, rst, start, busy, strobe, last, status;
  logic [3:0]  op, size_bytes, length_mod;
  logic [63:0] value;
  logic        is_signed, plus_sign, space_sign, alt_form, group_sep, has_precision;
  logic [5:0]  precision;
  logic [7:0]  out_char;

  request_t pending_reqs[$];
  char_t    expected_chars[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 19;
  bit       stim_done = 0;

  integer_to_text_formatter #(.MAX_PRECISION(PREC_CAP)) dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Push a short text as a run of characters
  task automatic push_text(input string s);
    char_t c;
    for (int k = 0; k < s.len(); k++) begin
      c.ch = s[k]; c.last = (k == s.len() - 1); c.status = 0;
      expected_chars.push_back(c);
    end
  endtask

  // Work out the character run a request should produce
  task automatic format_request(input request_t r);
    logic [63:0] mask, v, mag;
    logic [7:0]  digs[24];
    logic [7:0]  run[$];
    int          sz, msz, nd, len, nzero, base, p;
    bit          sgn, grp, hexf, octf, upper, neg, grouped;
    char_t       c;
    sgn = 0; grp = 0; hexf = 0; octf = 0; upper = 0; base = 10; nd = 0; nzero = 0;
    if (r.op > OP_SU) begin
      c.ch = CH_NUL; c.last = 1; c.status = 1;
      expected_chars.push_back(c);
      return;
    end
    sz = r.size_bytes > 8 ? 8 : r.size_bytes;
    case (r.length_mod)
      4'd1, 4'd11: msz = 1;
      4'd2, 4'd12: msz = 2;
      4'd9:        msz = 4;
      4'd13, 4'd14, 4'd15, 4'd0: msz = 0;
      default:     msz = 8;
    endcase
    if (msz != 0 && sz > msz) sz = msz;
    mask = (sz >= 8) ? '1 : ((64'd1 << (8 * sz)) - 1);
    v = r.value & mask;
    case (r.op)
      OP_C: begin
        c.ch = v[7:0]; c.last = 1; c.status = 0;
        expected_chars.push_back(c);
        return;
      end
      OP_SL: begin push_text(v != 0 ? "true" : "false"); return; end
      OP_SU: begin push_text(v != 0 ? "TRUE" : "FALSE"); return; end
      OP_DI: begin
        grp = 1;
        if (r.is_signed) begin
          sgn = 1;
          if (sz > 0 && sz < 8 && v[8 * sz - 1]) v = v | ~mask;
        end
      end
      OP_U:  grp = 1;
      OP_O:  begin base = 8; octf = 1; end
      OP_XL: begin base = 16; hexf = 1; end
      default: begin base = 16; hexf = 1; upper = 1; end
    endcase
    neg = sgn && v[63];
    mag = neg ? -v : v;
    do begin
      digs[nd] = 8'(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 0 && nd < 22);
    grouped = r.group_sep && grp;
    len = nd + (grouped ? (nd - 1) / 3 : 0);
    p = r.precision > PREC_CAP ? PREC_CAP : r.precision;
    if (r.has_precision && len < p) nzero = p - len;
    if (octf && r.alt_form && v != 0 && nzero == 0) nzero = 1;
    if (sgn) begin
      if (neg) run.push_back(CH_MINUS);
      else if (r.plus_sign) run.push_back(CH_PLUS);
      else if (r.space_sign) run.push_back(CH_SPACE);
    end
    if (hexf && r.alt_form && v != 0) begin
      run.push_back(CH_ZERO);
      run.push_back(upper ? CH_XU : CH_XL);
    end
    repeat (nzero) run.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) begin
      run.push_back(digs[i] < 10 ? 8'h30 + digs[i] : (upper ? 8'h37 : 8'h57) + digs[i]);
      if (grouped && i > 0 && i % 3 == 0) run.push_back(CH_COMMA);
    end
    if (run.size() > RUN_CAP) run = run[0:RUN_CAP-1];
    foreach (run[k]) begin
      c.ch = run[k]; c.last = (k == run.size() - 1); c.status = 0;
      expected_chars.push_back(c);
    end
  endtask

  function automatic request_t random_request();
    request_t r;
    r.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0: r.value = 64'($urandom_range(0, 1000));
      1: r.value = '1 - 64'($urandom_range(0, 1000));
      2: r.value = 64'd1 << $urandom_range(0, 63);
      default: r.value = {$urandom, $urandom};
    endcase
    r.is_signed = 1'($urandom_range(0, 1));
    r.size_bytes = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    r.length_mod = $urandom_range(0, 1) ? 4'd0 : 4'($urandom);
    {r.plus_sign, r.space_sign, r.alt_form, r.group_sep} = 4'($urandom);
    r.has_precision = 1'($urandom_range(0, 1));
    r.precision = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    return r;
  endfunction

  function automatic request_t make_req(input logic [3:0] o, input logic [63:0] v,
                                        input logic sg, input logic [3:0] sz,
                                        input logic [3:0] lm, input logic [3:0] flags,
                                        input logic hp, input logic [5:0] p);
    request_t r;
    r.op = o; r.value = v; r.is_signed = sg; r.size_bytes = sz; r.length_mod = lm;
    {r.plus_sign, r.space_sign, r.alt_form, r.group_sep} = flags;
    r.has_precision = hp; r.precision = p;
    return r;
  endfunction

  // Directed items, then three random phases with differing sender gaps
  initial begin
    pending_reqs.push_back(make_req(OP_DI, '1, 1, 8, 0, 4'b1000, 0, 0));
    pending_reqs.push_back(make_req(OP_DI, 64'h8000_0000_0000_0000, 1, 8, 0, 4'b0001, 0, 0));
    pending_reqs.push_back(make_req(OP_DI, 64'h7fff_ffff_ffff_ffff, 1, 8, 0, 4'b1001, 0, 0));
    pending_reqs.push_back(make_req(OP_DI, 5, 1, 8, 0, 4'b0100, 0, 0));
    pending_reqs.push_back(make_req(OP_DI, 64'h80, 1, 1, 0, 4'b0000, 1, 10));
    pending_reqs.push_back(make_req(OP_U, '1, 0, 8, 0, 4'b0001, 1, 63));
    pending_reqs.push_back(make_req(OP_U, 0, 0, 8, 0, 4'b0000, 1, 0));
    pending_reqs.push_back(make_req(OP_U, 64'h1234_5678, 0, 0, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_U, '1, 0, 15, 9, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_U, '1, 0, 8, 13, 4'b0001, 0, 0));
    pending_reqs.push_back(make_req(OP_O, 64'o777, 0, 8, 0, 4'b0010, 0, 0));
    pending_reqs.push_back(make_req(OP_O, 64'o7, 0, 8, 0, 4'b0010, 1, 5));
    pending_reqs.push_back(make_req(OP_O, 0, 0, 8, 0, 4'b0010, 0, 0));
    pending_reqs.push_back(make_req(OP_O, '1, 0, 8, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_XL, 64'hdead_beef, 0, 8, 0, 4'b0010, 0, 0));
    pending_reqs.push_back(make_req(OP_XL, 0, 0, 8, 0, 4'b0010, 0, 0));
    pending_reqs.push_back(make_req(OP_XU, '1, 1, 8, 1, 4'b1110, 1, 40));
    pending_reqs.push_back(make_req(OP_XU, '1, 0, 8, 12, 4'b0010, 1, 32));
    pending_reqs.push_back(make_req(OP_C, 64'h141, 0, 8, 0, 4'b1111, 1, 9));
    pending_reqs.push_back(make_req(OP_SL, 0, 0, 8, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_SL, 64'h100, 0, 1, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_SU, 1, 0, 8, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(OP_SU, 0, 0, 8, 0, 4'b0000, 0, 0));
    pending_reqs.push_back(make_req(4'd8, 1, 1, 8, 0, 4'b1111, 1, 5));
    pending_reqs.push_back(make_req(4'd15, '1, 0, 8, 0, 4'b0000, 0, 0));
    for (int ph = 0; ph < 3; ph++) begin
      repeat (68) pending_reqs.push_back(random_request());
      wait (pending_reqs.size() == 0);
      send_idle_pct = (ph == 0) ? 69 : 0;
    end
    stim_done = 1;
  end

  task automatic drive_fields(input request_t r);
    start <= 1;
    op <= r.op; value <= r.value; is_signed <= r.is_signed;
    size_bytes <= r.size_bytes; length_mod <= r.length_mod;
    plus_sign <= r.plus_sign; space_sign <= r.space_sign;
    alt_form <= r.alt_form; group_sep <= r.group_sep;
    has_precision <= r.has_precision; precision <= r.precision;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && !busy) begin
      format_request(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        drive_fields(pending_reqs[0]);
      end else begin
        start <= 0;
      end
    end else if (!start && pending_reqs.size() > 0 &&
                 $urandom_range(1, 100) > send_idle_pct) begin
      drive_fields(pending_reqs[0]);
    end
  end

  // Character monitor
  always @(posedge clk) begin
    char_t e;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h", out_char));
      end else begin
        e = expected_chars.pop_front();
        if (out_char !== e.ch)
          report($sformatf("out_char %h, expected %h", out_char, e.ch));
        if (last !== e.last)
          report($sformatf("last %b, expected %b", last, e.last));
        if (status !== e.status)
          report($sformatf("status %b, expected %b", status, e.status));
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stim_done && expected_chars.size() == 0);
        repeat (150) @(posedge clk);
      end
      wait (idle_cycles >= WD_LIMIT);
    join_any
    if (idle_cycles < WD_LIMIT && error_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_chars.size() != 0)
        $display("%0d characters never arrived", expected_chars.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/itc_pkg.sv
rtl/itc_narrow.sv
rtl/integer_to_text_formatter.sv
bench/tb.sv
